// ===== hdl/ubxpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ubxpc_pkg
// Shared types and constants for the UBX NAV-POSLLH frame checker.
// ----------------------------------------------------------------------------
package ubxpc_pkg;

  localparam int unsigned ByteW      = 8;
  // first captured frame index and number of captured field bytes
  localparam int unsigned FieldFirst = 2;
  localparam int unsigned FieldBytes = 32;
  localparam int unsigned FieldW     = FieldBytes * ByteW;

  // per-beat control shared by every capture cell
  typedef struct packed {
    logic beat;   // input beat accepted this cycle
    logic last;   // accepted beat closes the frame
  } cell_ctrl_t;

  // frame status from the checksum/position unit
  typedef struct packed {
    logic tok_start;  // next byte is the first field byte
    logic chk_ok;     // both trailing bytes match the sums
    logic too_long;   // frame ran past the maximum length
  } frame_stat_t;

endpackage

// ===== hdl/ubxpc_cell.sv =====
// ----------------------------------------------------------------------------
// ubxpc_cell
// One field-capture cell: holds a byte and a capture token that walks the row.
// ----------------------------------------------------------------------------
module ubxpc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ubxpc_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ubxpc_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                          tok_i,
  output logic                          tok_o,
  output logic [ubxpc_pkg::ByteW-1:0]   view_o
);

  logic                        tok_q, tok_d;
  logic [ubxpc_pkg::ByteW-1:0] byte_q, byte_d;

  // capture when the token sits here; token moves one cell per beat
  always_comb begin
    tok_d  = tok_q;
    byte_d = byte_q;
    if (ctrl_i.beat) begin
      if (ctrl_i.last) begin
        tok_d  = 1'b0;
        byte_d = '0;
      end else begin
        tok_d = tok_i;
        if (tok_q) begin
          byte_d = rx_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      byte_q <= '0;
    end else begin
      tok_q  <= tok_d;
      byte_q <= byte_d;
    end
  end

  // the closing byte itself may land in this cell
  assign view_o = tok_q ? rx_byte_i : byte_q;
  assign tok_o  = tok_q;

endmodule

// ===== hdl/ubxpc_fletcher.sv =====
// ----------------------------------------------------------------------------
// ubxpc_fletcher
// Byte position, two-byte delay line and the 8-bit Fletcher sums.
// ----------------------------------------------------------------------------
module ubxpc_fletcher #(
  parameter int unsigned MAX_FRAME = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ubxpc_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ubxpc_pkg::ByteW-1:0]   rx_byte_i,
  output ubxpc_pkg::frame_stat_t        stat_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME);

  logic [PosW-1:0]             pos_q, pos_d;
  logic [ubxpc_pkg::ByteW-1:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [ubxpc_pkg::ByteW-1:0] rb0_q, rb0_d, rb1_q, rb1_d;
  logic [ubxpc_pkg::ByteW-1:0] sum_a_new, sum_b_new;

  // byte two places back is now known to be inside the checksum span
  assign sum_a_new = (pos_q >= PosW'(4)) ? (sum_a_q + rb1_q) : sum_a_q;
  assign sum_b_new = (pos_q >= PosW'(4)) ? (sum_b_q + sum_a_new) : sum_b_q;

  always_comb begin
    pos_d   = pos_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    rb0_d   = rb0_q;
    rb1_d   = rb1_q;
    if (ctrl_i.beat) begin
      if (ctrl_i.last) begin
        pos_d   = '0;
        sum_a_d = '0;
        sum_b_d = '0;
        rb0_d   = '0;
        rb1_d   = '0;
      end else begin
        sum_a_d = sum_a_new;
        sum_b_d = sum_b_new;
        rb1_d   = rb0_q;
        rb0_d   = rx_byte_i;
        pos_d   = (pos_q < PosMax) ? pos_q + PosW'(1) : PosMax;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      rb0_q   <= '0;
      rb1_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      rb0_q   <= rb0_d;
      rb1_q   <= rb1_d;
    end
  end

  // verdict for a closing byte arriving now
  assign stat_o.tok_start = (pos_q == PosW'(ubxpc_pkg::FieldFirst - 1));
  assign stat_o.chk_ok    = (pos_q >= PosW'(3)) && (sum_a_new == rb0_q) &&
                            (sum_b_new == rx_byte_i);
  assign stat_o.too_long  = (pos_q >= PosMax);

endmodule

// ===== hdl/ubx_posllh_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// ubx_posllh_frame_checker_core
// UBX NAV-POSLLH frame checker: Fletcher checksum and field unpacking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one frame byte per beat,
//   with frame_end_i set on the frame's last byte. Output channel
//   (out_valid_o/out_ready_i) carries one verdict beat per frame: checksum
//   result, unpacked little-endian fields and a too-long flag.
//   Field bytes sit in a row of 32 capture cells; a one-hot token walks the
//   row one cell per beat. Throughput: one byte per cycle while no verdict
//   is stalled at the output. Latency: the verdict is registered and shows
//   on the cycle after the closing byte is accepted.
//   The next frame's bytes keep flowing as long as each verdict is taken
//   in the cycle it shows.
//   Stall: when out_valid_o is high and out_ready_i low, in_ready_o drops
//   and holds the input side; nothing is lost.
//   Reset: rst_ni clears the sums, position, capture row and output valid.
// ----------------------------------------------------------------------------
module ubx_posllh_frame_checker_core #(
  parameter int unsigned MAX_FRAME = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               checksum_ok_o,
  output logic [7:0]         msg_class_o,
  output logic [7:0]         msg_id_o,
  output logic [15:0]        payload_length_o,
  output logic [31:0]        time_of_week_o,
  output logic signed [31:0] longitude_o,
  output logic signed [31:0] latitude_o,
  output logic signed [31:0] height_ellipsoid_o,
  output logic signed [31:0] height_sea_level_o,
  output logic [31:0]        horiz_accuracy_o,
  output logic [31:0]        vert_accuracy_o,
  output logic               frame_too_long_o
);

  localparam int unsigned NCell = ubxpc_pkg::FieldBytes;
  localparam int unsigned BW    = ubxpc_pkg::ByteW;

  ubxpc_pkg::cell_ctrl_t     ctrl;
  ubxpc_pkg::frame_stat_t    stat;
  logic [NCell:0]            tok;
  logic [ubxpc_pkg::FieldW-1:0] views;
  logic                      beat;
  logic                      out_valid_q, out_valid_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign beat       = in_valid_i && in_ready_o;
  assign ctrl.beat  = beat;
  assign ctrl.last  = frame_end_i;

  // checksum and position
  ubxpc_fletcher #(
    .MAX_FRAME(MAX_FRAME)
  ) u_fletcher (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .rx_byte_i(rx_byte_i),
    .stat_o   (stat)
  );

  // row of capture cells, byte k of the row holds frame index k+2
  assign tok[0] = stat.tok_start;
  for (genvar k = 0; k < NCell; k++) begin : g_cell
    ubxpc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .rx_byte_i(rx_byte_i),
      .tok_i    (tok[k]),
      .tok_o    (tok[k+1]),
      .view_o   (views[k*BW +: BW])
    );
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (beat && frame_end_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload, loaded on the closing byte
  always_ff @(posedge clk_i) begin
    if (beat && frame_end_i) begin
      checksum_ok_o      <= stat.chk_ok;
      frame_too_long_o   <= stat.too_long;
      msg_class_o        <= views[7:0];
      msg_id_o           <= views[15:8];
      payload_length_o   <= views[31:16];
      time_of_week_o     <= views[63:32];
      longitude_o        <= views[95:64];
      latitude_o         <= views[127:96];
      height_ellipsoid_o <= views[159:128];
      height_sea_level_o <= views[191:160];
      horiz_accuracy_o   <= views[223:192];
      vert_accuracy_o    <= views[255:224];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ubxpc_checker.sv =====
// ----------------------------------------------------------------------------
// ubxpc_checker
// Port-level checks for the frame checker core, bound to the top level.
// ----------------------------------------------------------------------------
module ubxpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        frame_end_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        checksum_ok_o,
  input logic [31:0] time_of_week_o
);

  // a held verdict beat keeps its payload
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(checksum_ok_o) &&
                                    $stable(time_of_week_o))
    else $error("verdict beat changed while stalled");

  // input is stalled only by a pending, untaken verdict
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output space");

  // a closing byte yields a verdict on the next cycle
  a_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && frame_end_i |=> out_valid_o)
    else $error("closing byte gave no verdict");

  // no verdict appears without a closing byte
  a_no_extra : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) && !(in_valid_i && in_ready_o && frame_end_i)
    |=> !out_valid_o)
    else $error("verdict without a closing byte");

endmodule

bind ubx_posllh_frame_checker_core ubxpc_checker u_ubxpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .frame_end_i   (frame_end_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .checksum_ok_o (checksum_ok_o),
  .time_of_week_o(time_of_week_o)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the UBX NAV-POSLLH frame checker core. Frames are sent one
// byte per beat, and a scoreboard mirrors the running Fletcher sums and the
// field capture to predict each verdict. Each verdict beat is checked field
// by field. Both channels idle in random bursts, and one long output
// back-pressure stretch fills the core so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxFrame    = 255;
  localparam int unsigned ItemTarget  = 1650;
  localparam int unsigned QuietFrom   = 1450;
  localparam int unsigned LongFrom    = 600;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 300000;

  // header bytes of a well-formed NAV-POSLLH frame
  localparam logic [7:0] Sync1      = 8'hB5;
  localparam logic [7:0] Sync2      = 8'h62;
  localparam logic [7:0] ClassNav   = 8'h01;
  localparam logic [7:0] IdPosllh   = 8'h02;
  localparam logic [7:0] PosllhLen  = 8'd28;

  // content styles for frame bodies
  localparam int unsigned StyleRandom = 0;
  localparam int unsigned StyleZero   = 1;
  localparam int unsigned StyleOnes   = 2;
  localparam int unsigned StyleMinNeg = 3;
  localparam int unsigned StyleMaxPos = 4;

  typedef struct packed {
    logic               ok;
    logic [7:0]         cls;
    logic [7:0]         id;
    logic [15:0]        len;
    logic [31:0]        tow;
    logic signed [31:0] lon;
    logic signed [31:0] lat;
    logic signed [31:0] hae;
    logic signed [31:0] hmsl;
    logic [31:0]        hacc;
    logic [31:0]        vacc;
    logic               too_long;
  } verdict_t;

  // Mirrors the frame state and holds the verdicts still owed by the core.
  class PosllhScoreboard;
    bit [8:0]  byte_idx;
    bit [7:0]  sum_a;
    bit [7:0]  sum_b;
    bit [7:0]  prev_byte;
    bit [7:0]  prev_prev;
    bit [7:0]  field_bytes[ubxpc_pkg::FieldBytes];
    verdict_t  verdicts_due[$];
    int unsigned errors;

    function new();
      errors = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      byte_idx  = '0;
      sum_a     = '0;
      sum_b     = '0;
      prev_byte = '0;
      prev_prev = '0;
      foreach (field_bytes[k]) field_bytes[k] = '0;
    endfunction

    function logic [31:0] le32(int unsigned k);
      return {field_bytes[k+3], field_bytes[k+2], field_bytes[k+1], field_bytes[k]};
    endfunction

    // one accepted input beat
    function void note_byte(bit [7:0] b, bit last);
      verdict_t v;
      // byte two places back is now known not to be a checksum byte
      if (byte_idx >= 4) begin
        sum_a = sum_a + prev_prev;
        sum_b = sum_b + sum_a;
      end
      if (byte_idx >= ubxpc_pkg::FieldFirst &&
          byte_idx < ubxpc_pkg::FieldFirst + ubxpc_pkg::FieldBytes)
        field_bytes[byte_idx - ubxpc_pkg::FieldFirst] = b;
      if (!last) begin
        prev_prev = prev_byte;
        prev_byte = b;
        if (byte_idx < MaxFrame) byte_idx = byte_idx + 9'd1;
        return;
      end
      v.ok       = (byte_idx >= 3) && (sum_a == prev_byte) && (sum_b == b);
      v.cls      = field_bytes[0];
      v.id       = field_bytes[1];
      v.len      = {field_bytes[3], field_bytes[2]};
      v.tow      = le32(4);
      v.lon      = le32(8);
      v.lat      = le32(12);
      v.hae      = le32(16);
      v.hmsl     = le32(20);
      v.hacc     = le32(24);
      v.vacc     = le32(28);
      v.too_long = (byte_idx >= MaxFrame);
      verdicts_due.push_back(v);
      restart_frame();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      end
    endfunction

    // one accepted verdict beat
    function void check_verdict(verdict_t got);
      verdict_t exp;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected, expected none, actual %h", $time, got);
        return;
      end
      exp = verdicts_due.pop_front();
      compare_field("checksum_ok", 32'(exp.ok), 32'(got.ok));
      compare_field("msg_class", 32'(exp.cls), 32'(got.cls));
      compare_field("msg_id", 32'(exp.id), 32'(got.id));
      compare_field("payload_length", 32'(exp.len), 32'(got.len));
      compare_field("time_of_week", exp.tow, got.tow);
      compare_field("longitude", exp.lon, got.lon);
      compare_field("latitude", exp.lat, got.lat);
      compare_field("height_ellipsoid", exp.hae, got.hae);
      compare_field("height_sea_level", exp.hmsl, got.hmsl);
      compare_field("horiz_accuracy", exp.hacc, got.hacc);
      compare_field("vert_accuracy", exp.vacc, got.vacc);
      compare_field("frame_too_long", 32'(exp.too_long), 32'(got.too_long));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i;
  logic               frame_end_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               checksum_ok_o;
  logic [7:0]         msg_class_o;
  logic [7:0]         msg_id_o;
  logic [15:0]        payload_length_o;
  logic [31:0]        time_of_week_o;
  logic signed [31:0] longitude_o;
  logic signed [31:0] latitude_o;
  logic signed [31:0] height_ellipsoid_o;
  logic signed [31:0] height_sea_level_o;
  logic [31:0]        horiz_accuracy_o;
  logic [31:0]        vert_accuracy_o;
  logic               frame_too_long_o;

  PosllhScoreboard sb = new();
  bit [7:0]    frame_buf[$];
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  ubx_posllh_frame_checker_core #(
    .MAX_FRAME(MaxFrame)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .frame_end_i       (frame_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .checksum_ok_o     (checksum_ok_o),
    .msg_class_o       (msg_class_o),
    .msg_id_o          (msg_id_o),
    .payload_length_o  (payload_length_o),
    .time_of_week_o    (time_of_week_o),
    .longitude_o       (longitude_o),
    .latitude_o        (latitude_o),
    .height_ellipsoid_o(height_ellipsoid_o),
    .height_sea_level_o(height_sea_level_o),
    .horiz_accuracy_o  (horiz_accuracy_o),
    .vert_accuracy_o   (vert_accuracy_o),
    .frame_too_long_o  (frame_too_long_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // verdict monitor, sampled at the rising edge
  always @(posedge clk_i) begin : verdict_mon
    verdict_t got;
    if (out_valid_o && out_ready_i) begin
      got.ok       = checksum_ok_o;
      got.cls      = msg_class_o;
      got.id       = msg_id_o;
      got.len      = payload_length_o;
      got.tow      = time_of_week_o;
      got.lon      = longitude_o;
      got.lat      = latitude_o;
      got.hae      = height_ellipsoid_o;
      got.hmsl     = height_sea_level_o;
      got.hacc     = horiz_accuracy_o;
      got.vacc     = vert_accuracy_o;
      got.too_long = frame_too_long_o;
      sb.check_verdict(got);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req    = 1'b0;
        out_ready_i = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // one input beat; called at a falling edge, returns at a falling edge
  task automatic send_byte(input bit [7:0] b, input bit last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    rx_byte_i   = b;
    frame_end_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, last);
    items_sent++;
    if (items_sent >= QuietFrom) quiet = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // sender stops offering until every verdict has come back
  task automatic pause_until_drained();
    in_valid_i = 1'b0;
    while (sb.verdicts_due.size() != 0) @(negedge clk_i);
  endtask

  function automatic bit [7:0] content_byte(int unsigned style);
    case (style)
      StyleZero:   return 8'h00;
      StyleOnes:   return 8'hFF;
      StyleMinNeg: return 8'h80;
      StyleMaxPos: return 8'h7F;
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // sums cover index 2 to the current end; append the two check bytes
  function automatic void append_checksum();
    bit [7:0] a;
    bit [7:0] b;
    a = '0;
    b = '0;
    for (int i = 2; i < frame_buf.size(); i++) begin
      a = a + frame_buf[i];
      b = b + a;
    end
    frame_buf.push_back(a);
    frame_buf.push_back(b);
  endfunction

  function automatic void build_posllh(int unsigned style);
    frame_buf.delete();
    frame_buf = '{Sync1, Sync2, ClassNav, IdPosllh, PosllhLen, 8'h00};
    repeat (PosllhLen) frame_buf.push_back(content_byte(style));
    append_checksum();
  endfunction

  function automatic void build_random(int unsigned len, bit with_sum, int unsigned style);
    frame_buf.delete();
    if (with_sum && len >= 4) begin
      repeat (len - 2) frame_buf.push_back(content_byte(style));
      append_checksum();
    end else begin
      repeat (len) frame_buf.push_back(content_byte(style));
    end
  endfunction

  // single bit flip anywhere in the frame
  function automatic void corrupt_frame();
    int unsigned idx;
    idx = $urandom_range(0, frame_buf.size() - 1);
    frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
  endfunction

  function automatic int unsigned pick_style();
    int unsigned r;
    r = $urandom_range(0, 9);
    return (r <= StyleMaxPos) ? r : StyleRandom;
  endfunction

  // main sequence
  initial begin
    int unsigned pick;
    bit          long_done;
    long_done   = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    frame_end_i = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: one, two and three byte frames fail
    frame_buf = '{8'h00};
    send_frame();
    frame_buf = '{8'hFF, 8'hFF};
    send_frame();
    frame_buf = '{Sync1, Sync2, ClassNav};
    send_frame();
    // four bytes: empty sum range, zero check bytes pass
    frame_buf = '{Sync1, Sync2};
    append_checksum();
    send_frame();
    // all-ones fields, later field bytes never arrive
    frame_buf.delete();
    repeat (10) frame_buf.push_back(8'hFF);
    append_checksum();
    send_frame();

    // long output hold-off while short frames keep coming
    hold_req = 1'b1;
    repeat (12) begin
      build_random($urandom_range(1, 6), $urandom_range(0, 1), pick_style());
      send_frame();
    end
    pause_until_drained();

    // random frames, mostly well formed
    while (items_sent < ItemTarget) begin
      if (!long_done && items_sent >= LongFrom) begin
        // one just under the limit, one past it (position saturates)
        build_random(MaxFrame, 1'b1, pick_style());
        send_frame();
        build_random(MaxFrame + 1 + $urandom_range(0, 44), 1'b1, pick_style());
        send_frame();
        long_done = 1'b1;
        pause_until_drained();
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        build_posllh(pick_style());
        if ($urandom_range(0, 4) == 0) corrupt_frame();
      end else if (pick <= 8) begin
        build_random($urandom_range(1, 40), $urandom_range(0, 1), pick_style());
      end else begin
        build_random($urandom_range(1, 5), 1'b0, pick_style());
      end
      send_frame();
    end

    pause_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
